@@ rtl/sorted_list_insert_delete_defines.svh @@
// Assertion macros shared by the sorted list design.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SLID_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted list check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SLID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted list check failed");

`endif

@@ rtl/slid_pkg.sv @@
`default_nettype none
package slid_pkg;

   // Number of list cells in the chain.
   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the stream channels.
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      op_type                     op;
      logic                       do_insert;
      logic                       do_delete;
      logic signed [VALUE_W-1:0]  value;
      logic [CNT_W-1:0]           count;
   } cell_ctrl_type;

   // Status that each cell hands to its upper neighbor and to the top level.
   typedef struct packed {
      logic le;   // occupied and stored value <= request value
      logic eq;   // occupied and stored value == request value
      logic hit;  // this cell is the position used by the request
   } cell_flags_type;

   // One result beat.
   typedef struct packed {
      logic               done_res;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/slid_cell.sv @@
`default_nettype none
module slid_cell (
   input  wire                                       clock,
   input  wire  [slid_pkg::IDX_W-1:0]                index,
   input  slid_pkg::cell_ctrl_type                   ctrl,
   input  wire  signed [slid_pkg::VALUE_W-1:0]       entry_below,
   input  wire  signed [slid_pkg::VALUE_W-1:0]       entry_above,
   input  slid_pkg::cell_flags_type                  flags_below,
   output logic signed [slid_pkg::VALUE_W-1:0]       entry,
   output slid_pkg::cell_flags_type                  flags
);

   logic signed [slid_pkg::VALUE_W-1:0] entry_ff;
   logic signed [slid_pkg::VALUE_W-1:0] entry_in;
   logic                                occupied;
   logic                                ge;
   logic                                ins_here;
   logic                                first_eq;

   // Compare the stored value against the broadcast request.
   always_comb begin
      occupied = slid_pkg::CNT_W'(index) < ctrl.count;
      flags.le = occupied && (entry_ff <= ctrl.value);
      flags.eq = occupied && (entry_ff == ctrl.value);
      ge       = occupied && !(entry_ff < ctrl.value);
      // The insertion point is the first cell whose value is not <= the request.
      ins_here = !flags.le && flags_below.le;
      // Equal values sit next to each other, so the first match has no match below.
      first_eq = flags.eq && !flags_below.eq;
      flags.hit = (ctrl.op == slid_pkg::OP_INSERT) ? ins_here : first_eq;
   end

   // Shift up on insert, shift down on delete, otherwise hold.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert) begin
         if (!flags_below.le) begin
            entry_in = entry_below;
         end else if (!flags.le) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.do_delete && ge) begin
         entry_in = entry_above;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

@@ rtl/slid_rsp_buf.sv @@
`default_nettype none
module slid_rsp_buf (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  slid_pkg::rsp_type   push_data,
   output logic                push_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output slid_pkg::rsp_type   rsp_data
);

   logic              main_valid_ff;
   logic              main_valid_in;
   slid_pkg::rsp_type main_data_ff;
   slid_pkg::rsp_type main_data_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   slid_pkg::rsp_type skid_data_ff;
   slid_pkg::rsp_type skid_data_in;
   logic              pop;

   assign pop        = main_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;

   // Output register with a skid stage behind it.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         main_valid_in = skid_valid_ff || push;
         main_data_in  = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule
`default_nettype wire

@@ rtl/sorted_list_insert_delete.sv @@
// Sorted list of signed 32-bit values held in a chain of compare-and-shift cells.
// Request channel (req_): tuser bit 0 is the operation (0 insert, 1 delete),
// tdata is the signed value. Result channel (rsp_): tuser bit 0 is done_res,
// tdata bits 4:0 are the position and bits 10:5 the entry count afterwards.
// Every request beat yields exactly one result beat, in order.
// The result is registered in the output buffer and shows on rsp_ once the
// results ahead of it are taken. Throughput: one request per cycle while req_tready
// is high; each cell compares its entry with the broadcast value and shifts within
// that same cycle, so the next request sees the updated list at once.
// An insert into a full list, or a delete that finds no equal entry, leaves the
// list unchanged and returns done_res 0, position 0.
// Reset (synchronous, active high) empties the list; entry contents are not
// cleared, since entries at or above the count are never used.
// When the receiver stalls, one more result is held in a skid stage; after that
// req_tready drops until rsp_ beats are taken again.
`default_nettype none
`include "sorted_list_insert_delete_defines.svh"
module sorted_list_insert_delete (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] position, [10:5] count, [15:11] zero
   output logic [0:0]  rsp_tuser    // [0] done_res
);

   localparam int N = slid_pkg::CAPACITY;

   logic [slid_pkg::CNT_W-1:0]          count_ff;
   logic [slid_pkg::CNT_W-1:0]          count_in;
   logic                                accept;
   logic                                full;
   logic                                any_match;
   logic                                done;
   logic [slid_pkg::IDX_W-1:0]          pos_idx;
   slid_pkg::op_type                    op;
   slid_pkg::cell_ctrl_type             ctrl;
   slid_pkg::rsp_type                   result;
   slid_pkg::rsp_type                   rsp_data;
   logic signed [slid_pkg::VALUE_W-1:0] entry_w [N];
   slid_pkg::cell_flags_type            flags_w [N];

   assign accept = req_tvalid && req_tready;
   assign op     = slid_pkg::op_type'(req_tuser[0]);
   assign full   = count_ff == slid_pkg::CNT_W'(N);

   // Combine the cell flags into the position used and the match summary.
   always_comb begin
      any_match = 1'b0;
      pos_idx   = '0;
      for (int k = 0; k < N; k++) begin
         any_match = any_match | flags_w[k].eq;
         pos_idx   = pos_idx | (flags_w[k].hit ? slid_pkg::IDX_W'(k) : '0);
      end
      done = (op == slid_pkg::OP_INSERT) ? !full : any_match;
   end

   // Control broadcast to all cells.
   always_comb begin
      ctrl.op        = op;
      ctrl.value     = $signed(req_tdata);
      ctrl.count     = count_ff;
      ctrl.do_insert = accept && (op == slid_pkg::OP_INSERT) && !full;
      ctrl.do_delete = accept && (op == slid_pkg::OP_DELETE) && any_match;
   end

   // Entry count update.
   always_comb begin
      count_in = count_ff;
      if (ctrl.do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.do_delete) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Chain of cells; the bottom cell sees a neighbor that is always <= and
   // never equal, the top cell shifts in don't-care data.
   for (genvar g = 0; g < N; g++) begin : g_cell
      logic signed [slid_pkg::VALUE_W-1:0] below;
      logic signed [slid_pkg::VALUE_W-1:0] above;
      slid_pkg::cell_flags_type            fbelow;

      if (g == 0) begin : g_bottom
         assign below  = '0;
         assign fbelow = '{le: 1'b1, eq: 1'b0, hit: 1'b0};
      end else begin : g_inner
         assign below  = entry_w[g-1];
         assign fbelow = flags_w[g-1];
      end

      if (g == N - 1) begin : g_top
         assign above = '0;
      end else begin : g_lower
         assign above = entry_w[g+1];
      end

      slid_cell u_cell (
         .clock       (clock),
         .index       (slid_pkg::IDX_W'(g)),
         .ctrl        (ctrl),
         .entry_below (below),
         .entry_above (above),
         .flags_below (fbelow),
         .entry       (entry_w[g]),
         .flags       (flags_w[g])
      );
   end

   // Result beat for the accepted request.
   always_comb begin
      result.done_res = done;
      result.position = done ? slid_pkg::POS_W'(pos_idx) : '0;
      result.count    = slid_pkg::COUNT_W'(count_in);
   end

   slid_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tuser = rsp_data.done_res;
   assign rsp_tdata = {5'b0, rsp_data.count, rsp_data.position};

   // Checks on the list bookkeeping and the result buffering.
   `SLID_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= slid_pkg::CNT_W'(N))
   `SLID_ASSERT_NEXT(a_full_insert_holds, clock, reset,
      accept && (op == slid_pkg::OP_INSERT) && full, $stable(count_ff))
   `SLID_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.do_insert,
      count_ff == $past(count_ff) + 1'b1)
   `SLID_ASSERT_NOW(a_stall_has_result, clock, reset, !req_tready, rsp_tvalid)

endmodule
`default_nettype wire
